// ----- design/lcee_pkg.sv -----
// ----------------------------------------------------------------------------
// lcee_pkg
// shared types, register indexes and constants of the led colour effect engine
// ----------------------------------------------------------------------------
package lcee_pkg;

    typedef enum logic [1:0] {
        MODE_SOLID  = 2'd0,
        MODE_PULSE  = 2'd1,
        MODE_VOLUME = 2'd2,
        MODE_BEAT   = 2'd3
    } mode_t;

    localparam logic [2:0] REG_EFFECT_MODE      = 3'd0;
    localparam logic [2:0] REG_PRIMARY_COLOUR   = 3'd1;
    localparam logic [2:0] REG_SECONDARY_COLOUR = 3'd2;
    localparam logic [2:0] REG_PULSE_INTERVAL   = 3'd3;
    localparam logic [2:0] REG_PULSE_STEP       = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [15:0] VOLUME_INTERVAL = 16'd136;
    localparam logic [15:0] BEAT_INTERVAL   = 16'd6;
    localparam logic [7:0]  LEVEL_SLEW      = 8'd10;
    localparam logic [5:0]  BEAT_STEP       = 6'd10;

    localparam logic [23:0] PRIMARY_RESET   = 24'h0000FF;
    localparam logic [23:0] SECONDARY_RESET = 24'h000000;
    localparam logic [15:0] INTERVAL_RESET  = 16'd120;
    localparam logic [5:0]  STEP_RESET      = 6'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t COLOUR_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd255};

    typedef struct packed {
        logic        expire;
        logic [15:0] count_next;
    } tick_t;

    function automatic logic [7:0] approach(input logic [7:0] cur,
                                            input logic [7:0] target,
                                            input logic [5:0] step);
        logic [7:0] diff;
        logic [7:0] step_w;
        logic [7:0] res;
        step_w = {2'b00, step};
        if (cur < target)
        begin
            diff = target - cur;
            res  = (diff < step_w) ? target : cur + step_w;
        end
        else
        begin
            diff = cur - target;
            res  = (diff < step_w) ? target : cur - step_w;
        end
        return res;
    endfunction

    function automatic rgb_t move_toward(input rgb_t cur, input rgb_t target,
                                         input logic [5:0] step);
        rgb_t res;
        res.red   = approach(cur.red, target.red, step);
        res.green = approach(cur.green, target.green, step);
        res.blue  = approach(cur.blue, target.blue, step);
        return res;
    endfunction

endpackage

// ----- design/lcee_tick_div.sv -----
// ----------------------------------------------------------------------------
// lcee_tick_div
// tick divider: picks the update interval of the mode and checks expiry
// ----------------------------------------------------------------------------
module lcee_tick_div
(
    input  lcee_pkg::mode_t  mode,
    input  logic [15:0]      pulse_interval,
    input  logic [15:0]      tick_count,
    output lcee_pkg::tick_t  tick
);
    import lcee_pkg::*;

    logic [15:0] interval;
    logic [16:0] count;

    always_comb
    begin
        unique case (mode)
            MODE_PULSE:  interval = (pulse_interval == 16'd0) ? 16'd1 : pulse_interval;
            MODE_VOLUME: interval = VOLUME_INTERVAL;
            MODE_BEAT:   interval = BEAT_INTERVAL;
            default:     interval = 16'd1;
        endcase
    end

    assign count           = {1'b0, tick_count} + 17'd1;
    assign tick.expire     = (count >= {1'b0, interval});
    assign tick.count_next = tick.expire ? 16'd0 : count[15:0];

endmodule

// ----- design/lcee_colour_step.sv -----
// ----------------------------------------------------------------------------
// lcee_colour_step
// next strip colour, pulse direction and level for one update
// ----------------------------------------------------------------------------
module lcee_colour_step
(
    input  lcee_pkg::mode_t  mode,
    input  lcee_pkg::rgb_t   primary,
    input  lcee_pkg::rgb_t   secondary,
    input  logic [5:0]       pulse_step,
    input  lcee_pkg::rgb_t   colour,
    input  logic             toward_primary,
    input  logic [7:0]       last_level,
    input  logic [7:0]       level,
    input  logic             beat,
    output lcee_pkg::rgb_t   colour_next,
    output logic             toward_primary_next,
    output logic [7:0]       last_level_next
);
    import lcee_pkg::*;

    rgb_t        pulse_target;
    rgb_t        pulse_colour;
    rgb_t        beat_colour;
    rgb_t        volume_colour;
    logic [7:0]  slew_level;
    logic [15:0] prod_red;
    logic [15:0] prod_green;
    logic [15:0] prod_blue;

    assign pulse_target = toward_primary ? primary : secondary;
    assign pulse_colour = move_toward(colour, pulse_target, pulse_step);
    assign beat_colour  = move_toward(colour, beat ? primary : secondary, BEAT_STEP);

    // slew limit of the audio level
    always_comb
    begin
        if (level > last_level && (level - last_level) > LEVEL_SLEW)
            slew_level = last_level + LEVEL_SLEW;
        else if (level < last_level && (last_level - level) > LEVEL_SLEW)
            slew_level = last_level - LEVEL_SLEW;
        else
            slew_level = level;
    end

    assign prod_red            = primary.red * slew_level;
    assign prod_green          = primary.green * slew_level;
    assign prod_blue           = primary.blue * slew_level;
    assign volume_colour.red   = prod_red[15:8];
    assign volume_colour.green = prod_green[15:8];
    assign volume_colour.blue  = prod_blue[15:8];

    always_comb
    begin
        colour_next         = colour;
        toward_primary_next = toward_primary;
        last_level_next     = last_level;
        unique case (mode)
            MODE_PULSE:
            begin
                colour_next = pulse_colour;
                if (pulse_colour == pulse_target)
                    toward_primary_next = ~toward_primary;
            end
            MODE_VOLUME:
            begin
                colour_next     = volume_colour;
                last_level_next = slew_level;
            end
            MODE_BEAT:
            begin
                colour_next = beat_colour;
            end
            default:
            begin
                colour_next = colour;
            end
        endcase
    end

endmodule

// ----- design/led_colour_effect_engine.sv -----
// ----------------------------------------------------------------------------
// led_colour_effect_engine
// divides timer ticks and emits pulse, volume or beat fade strip colours
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  audio_level, beat_high
//  out       source     out_valid / out_stall red, green, blue, heading_primary
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
//  one word per cycle while out_stall is low; a tick word sits in the input
//  register and its colour is loaded into the result register when it fires
//  state update and result load happen in the same cycle, from short logic
//  reset loads register defaults and colour state and clears both valid flags
//  a stalled result holds; the input register still takes one more word
// ----------------------------------------------------------------------------
module led_colour_effect_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lcee_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lcee_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          audio_level,
    input  logic                                beat_high,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic                                heading_primary
);
    import lcee_pkg::*;

    mode_t       mode_reg;
    rgb_t        primary_reg;
    rgb_t        secondary_reg;
    logic [15:0] interval_reg;
    logic [5:0]  step_reg;

    rgb_t        colour_reg;
    logic        toward_reg;
    logic [7:0]  last_level_reg;
    logic [15:0] tick_count_reg;

    logic        in_valid_reg;
    logic [7:0]  level_reg;
    logic        beat_reg;

    logic        out_valid_reg;
    rgb_t        out_colour_reg;
    logic        out_heading_reg;

    tick_t       tick;
    rgb_t        colour_next;
    logic        toward_next;
    logic [7:0]  last_level_next;
    logic        fire;
    logic        active;
    logic        produce;
    logic        in_accept;

    lcee_tick_div u_tick_div
    (
        .mode           (mode_reg),
        .pulse_interval (interval_reg),
        .tick_count     (tick_count_reg),
        .tick           (tick)
    );

    lcee_colour_step u_colour_step
    (
        .mode                (mode_reg),
        .primary             (primary_reg),
        .secondary           (secondary_reg),
        .pulse_step          (step_reg),
        .colour              (colour_reg),
        .toward_primary      (toward_reg),
        .last_level          (last_level_reg),
        .level               (level_reg),
        .beat                (beat_reg),
        .colour_next         (colour_next),
        .toward_primary_next (toward_next),
        .last_level_next     (last_level_next)
    );

    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;
    assign active    = (mode_reg != MODE_SOLID);
    assign produce   = active && tick.expire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SOLID;
            primary_reg   <= rgb_t'(PRIMARY_RESET);
            secondary_reg <= rgb_t'(SECONDARY_RESET);
            interval_reg  <= INTERVAL_RESET;
            step_reg      <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:      mode_reg      <= mode_t'(cfg_data[1:0]);
                REG_PRIMARY_COLOUR:   primary_reg   <= rgb_t'(cfg_data[23:0]);
                REG_SECONDARY_COLOUR: secondary_reg <= rgb_t'(cfg_data[23:0]);
                REG_PULSE_INTERVAL:   interval_reg  <= cfg_data[15:0];
                REG_PULSE_STEP:       step_reg      <= cfg_data[5:0];
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg <= audio_level;
            beat_reg  <= beat_high;
        end
    end

    // effect state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg     <= COLOUR_RESET;
            toward_reg     <= 1'b0;
            last_level_reg <= 8'd0;
            tick_count_reg <= 16'd0;
        end
        else if (fire && active)
        begin
            tick_count_reg <= tick.count_next;
            if (tick.expire)
            begin
                colour_reg     <= colour_next;
                toward_reg     <= toward_next;
                last_level_reg <= last_level_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= produce;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            out_colour_reg  <= colour_next;
            out_heading_reg <= toward_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign red             = out_colour_reg.red;
    assign green           = out_colour_reg.green;
    assign blue            = out_colour_reg.blue;
    assign heading_primary = out_heading_reg;

`ifndef ASSERT_OFF
    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && produce |=> tick_count_reg == 16'd0)
        else $error("tick count not cleared after update");

    a_solid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !active && !cfg_we |=> $stable(tick_count_reg) && $stable(colour_reg))
        else $error("solid mode changed effect state");

    a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(fire))
        else $error("result appeared without an update");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a held word");
`endif

endmodule
